@@ design/almagc_pkg.sv @@
// Shared types and constants for the ADC level monitor with gain control.
`timescale 1ns / 1ps

package almagc_pkg;

  localparam int PCT_BITS   = 7;
  localparam int GAIN_BITS  = 6;
  localparam int PADDR_BITS = 5;
  localparam int PDATA_BITS = 32;

  // Register map, byte address = 4 * index
  typedef enum logic [2:0] {
    REG_UPPER_LIMIT     = 3'd0,
    REG_LOWER_LIMIT     = 3'd1,
    REG_TARGET_LEVEL    = 3'd2,
    REG_COARSE_MAX      = 3'd3,
    REG_FINE_LOW        = 3'd4,
    REG_FINE_HIGH       = 3'd5,
    REG_FINE_AFTER_DOWN = 3'd6,
    REG_FINE_AFTER_UP   = 3'd7
  } reg_idx_t;

  localparam logic [PCT_BITS-1:0]  RST_UPPER_LIMIT     = 7'd40;
  localparam logic [PCT_BITS-1:0]  RST_LOWER_LIMIT     = 7'd20;
  localparam logic [PCT_BITS-1:0]  RST_TARGET_LEVEL    = 7'd30;
  localparam logic [GAIN_BITS-1:0] RST_COARSE_MAX      = 6'd23;
  localparam logic [GAIN_BITS-1:0] RST_FINE_LOW        = 6'd7;
  localparam logic [GAIN_BITS-1:0] RST_FINE_HIGH       = 6'd26;
  localparam logic [GAIN_BITS-1:0] RST_FINE_AFTER_DOWN = 6'd22;
  localparam logic [GAIN_BITS-1:0] RST_FINE_AFTER_UP   = 6'd14;

  localparam logic [GAIN_BITS-1:0] COARSE_RESET = 6'd12;
  localparam logic [GAIN_BITS-1:0] FINE_RESET   = 6'd15;

  localparam logic [PCT_BITS-1:0] PCT_FULL = 7'd100;

  typedef struct packed {
    logic [1:0]  front_end;
    logic [31:0] count_minus3;
    logic [31:0] count_minus1;
    logic [31:0] count_plus1;
    logic [31:0] count_plus3;
  } in_item_t;

  typedef struct packed {
    logic [1:0]           unit;
    logic [PCT_BITS-1:0]  sign_percent;
    logic [PCT_BITS-1:0]  mag_percent;
    logic [GAIN_BITS-1:0] coarse_gain;
    logic [GAIN_BITS-1:0] fine_gain;
  } out_item_t;

  typedef struct packed {
    logic [PCT_BITS-1:0]  upper_limit;
    logic [PCT_BITS-1:0]  lower_limit;
    logic [PCT_BITS-1:0]  target_level;
    logic [GAIN_BITS-1:0] coarse_max;
    logic [GAIN_BITS-1:0] fine_low;
    logic [GAIN_BITS-1:0] fine_high;
    logic [GAIN_BITS-1:0] fine_after_down;
    logic [GAIN_BITS-1:0] fine_after_up;
  } agc_cfg_t;

  typedef struct packed {
    logic                valid;
    logic [1:0]          front_end;
    logic [PCT_BITS-1:0] mag;
  } gain_req_t;

endpackage

@@ design/almagc_gain.sv @@
// Per-front-end coarse/fine gain store and one-step gain update.
`timescale 1ns / 1ps

module almagc_gain import almagc_pkg::*; #(
  parameter int FRONT_ENDS = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  agc_cfg_t             cfg,
  input  gain_req_t            req,
  output logic [GAIN_BITS-1:0] coarse_gain,
  output logic [GAIN_BITS-1:0] fine_gain
);

  localparam int FE_W = (FRONT_ENDS > 1) ? $clog2(FRONT_ENDS) : 1;

  logic [GAIN_BITS-1:0] coarse_store [FRONT_ENDS];
  logic [GAIN_BITS-1:0] fine_store   [FRONT_ENDS];

  logic [FE_W+1:0]      fe_ext;
  logic                 in_range;
  logic [FE_W-1:0]      idx;
  logic [GAIN_BITS-1:0] c_cur, f_cur, c_next, f_next;

  assign fe_ext   = (FE_W+2)'(req.front_end);
  assign in_range = fe_ext < (FE_W+2)'(FRONT_ENDS);
  assign idx      = in_range ? fe_ext[FE_W-1:0] : '0;
  assign c_cur    = coarse_store[idx];
  assign f_cur    = fine_store[idx];

  always_comb begin
    c_next = c_cur;
    f_next = f_cur;
    priority if (((req.mag > cfg.upper_limit) && (c_cur != '0)) ||
                 (f_cur <= cfg.fine_low)) begin
      c_next = (c_cur != '0) ? c_cur - 1'b1 : '0;
      f_next = cfg.fine_after_down;
    end else if (((req.mag < cfg.lower_limit) && (c_cur < cfg.coarse_max)) ||
                 (f_cur >= cfg.fine_high)) begin
      c_next = (c_cur < cfg.coarse_max) ? c_cur + 1'b1 : cfg.coarse_max;
      f_next = cfg.fine_after_up;
    end else if ((req.mag < cfg.target_level) && (req.mag >= cfg.lower_limit)) begin
      f_next = f_cur + 1'b1;
    end else if ((req.mag > cfg.target_level) && (req.mag <= cfg.upper_limit)) begin
      f_next = f_cur - 1'b1;
    end else begin
      f_next = f_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < FRONT_ENDS; i++) begin
        coarse_store[i] <= COARSE_RESET;
        fine_store[i]   <= FINE_RESET;
      end
      coarse_gain <= '0;
      fine_gain   <= '0;
    end else if (req.valid) begin
      if (in_range) begin
        coarse_store[idx] <= c_next;
        fine_store[idx]   <= f_next;
      end
      coarse_gain <= in_range ? c_next : '0;
      fine_gain   <= in_range ? f_next : '0;
    end
  end

`ifndef SYNTH
  // an out-of-range front end reports zero gains
  a_out_of_range_zero: assert property (@(posedge clk) disable iff (rst)
    (req.valid && !in_range) |=> (coarse_gain == '0) && (fine_gain == '0))
    else $error("gain reported for a front end that does not exist");

  // a coarse step never moves more than one step, except the pull to coarse_max
  a_coarse_step: assert property (@(posedge clk) disable iff (rst)
    (req.valid && in_range) |-> (c_next == c_cur) || (c_next == c_cur + 1'b1) ||
      (c_next == c_cur - 1'b1) || (c_next == cfg.coarse_max))
    else $error("coarse gain jumped by more than one step");
`endif

endmodule

@@ design/adc_level_monitor_agc.sv @@
// Top level: ADC level monitor, percentage computation and gain control.
`timescale 1ns / 1ps

// ADC level monitor with automatic gain control. Each input transfer carries
// one front end's 2-bit ADC level histogram (counts at -3, -1, +1, +3). The
// block returns one result transfer with the weighted sign percentage
// floor(100*(3*p3+p1)/(3*p3+p1+3*m3+m1)), the magnitude percentage
// floor(100*(p3+m3)/total), and that front end's coarse/fine gain after one
// control step driven by the magnitude. A zero divisor gives 0 percent. A
// front end number at or above FRONT_ENDS reports both percentages, leaves
// all gain state alone and returns zero gains. Gains reset to coarse 12 and
// fine 15 on every front end.
// Timing: one item at a time. A result is loaded into the output register in
// S_OUT, and the next input can be taken in the following cycle; S_OUT
// waits while the output register still holds an unaccepted result. All of
// the work is done on the one shared (COUNT_BITS+10)-bit adder /
// subtractor: the count sums in S_POS3 through S_TOT, then per percentage
// the times-100 product in S_MUL1 and S_MUL2 and 7 restoring divide steps;
// S_GAIN updates the gain store and S_OUT loads the output. The output
// register lets the next input in while a result still waits for out_ready.
// Config: APB writes (pready is always high) to registers at 4*index:
// upper_limit, lower_limit, target_level, coarse_max, fine_low, fine_high,
// fine_after_down, fine_after_up. Write them only while the block is idle.

module adc_level_monitor_agc import almagc_pkg::*; #(
  parameter int FRONT_ENDS = 4,
  parameter int COUNT_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [PDATA_BITS-1:0] pwdata,
  output logic [PDATA_BITS-1:0] prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data
);

  // sums reach 8*max count; 100*sum stays below 128*max divisor
  localparam int SW = COUNT_BITS + 3;
  localparam int AW = COUNT_BITS + 10;
  localparam logic [2:0] Q_MSB = 3'(PCT_BITS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_POS3, S_POS, S_SIG3, S_SIG1, S_SIG, S_MAG, S_TOT1, S_TOT,
    S_MUL1, S_MUL2, S_DIV, S_GAIN, S_OUT
  } state_t;

  state_t state;

  // ---------------------------------------------------------------- config
  agc_cfg_t cfg;
  logic     cfg_wr;
  reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[PADDR_BITS-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.upper_limit     <= RST_UPPER_LIMIT;
      cfg.lower_limit     <= RST_LOWER_LIMIT;
      cfg.target_level    <= RST_TARGET_LEVEL;
      cfg.coarse_max      <= RST_COARSE_MAX;
      cfg.fine_low        <= RST_FINE_LOW;
      cfg.fine_high       <= RST_FINE_HIGH;
      cfg.fine_after_down <= RST_FINE_AFTER_DOWN;
      cfg.fine_after_up   <= RST_FINE_AFTER_UP;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_UPPER_LIMIT:     cfg.upper_limit     <= pwdata[PCT_BITS-1:0];
        REG_LOWER_LIMIT:     cfg.lower_limit     <= pwdata[PCT_BITS-1:0];
        REG_TARGET_LEVEL:    cfg.target_level    <= pwdata[PCT_BITS-1:0];
        REG_COARSE_MAX:      cfg.coarse_max      <= pwdata[GAIN_BITS-1:0];
        REG_FINE_LOW:        cfg.fine_low        <= pwdata[GAIN_BITS-1:0];
        REG_FINE_HIGH:       cfg.fine_high       <= pwdata[GAIN_BITS-1:0];
        REG_FINE_AFTER_DOWN: cfg.fine_after_down <= pwdata[GAIN_BITS-1:0];
        REG_FINE_AFTER_UP:   cfg.fine_after_up   <= pwdata[GAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_UPPER_LIMIT:     prdata = PDATA_BITS'(cfg.upper_limit);
      REG_LOWER_LIMIT:     prdata = PDATA_BITS'(cfg.lower_limit);
      REG_TARGET_LEVEL:    prdata = PDATA_BITS'(cfg.target_level);
      REG_COARSE_MAX:      prdata = PDATA_BITS'(cfg.coarse_max);
      REG_FINE_LOW:        prdata = PDATA_BITS'(cfg.fine_low);
      REG_FINE_HIGH:       prdata = PDATA_BITS'(cfg.fine_high);
      REG_FINE_AFTER_DOWN: prdata = PDATA_BITS'(cfg.fine_after_down);
      REG_FINE_AFTER_UP:   prdata = PDATA_BITS'(cfg.fine_after_up);
      default:             prdata = '0;
    endcase
  end

  // -------------------------------------------------------------- datapath
  logic [1:0]            r_fe;
  logic [COUNT_BITS-1:0] r_m3, r_m1, r_p1, r_p3;
  logic [SW-1:0]         r_pos, r_sig, r_mag, r_tot;
  logic [AW-1:0]         acc;          // running sum, then division remainder
  logic [PCT_BITS-1:0]   r_q, r_sign, r_magpct;
  logic [2:0]            k;            // current quotient bit
  logic                  div_sel;      // 0: sign percentage, 1: magnitude

  logic [SW-1:0]         num, den;
  logic                  den_zero;
  logic [AW-1:0]         op_a, op_b;
  logic                  op_sub;
  logic [AW:0]           sum;
  logic                  ge;
  logic [PCT_BITS-1:0]   q_res;

  assign num      = div_sel ? r_mag : r_pos;
  assign den      = div_sel ? r_tot : r_sig;
  assign den_zero = (den == '0);

  // the one shared adder / subtractor
  always_comb begin
    op_a   = '0;
    op_b   = '0;
    op_sub = 1'b0;
    unique case (state)
      S_POS3: begin op_a = AW'(r_p3) << 1;  op_b = AW'(r_p3);        end
      S_POS:  begin op_a = acc;             op_b = AW'(r_p1);        end
      S_SIG3: begin op_a = AW'(r_m3) << 1;  op_b = AW'(r_m3);        end
      S_SIG1: begin op_a = acc;             op_b = AW'(r_m1);        end
      S_SIG:  begin op_a = acc;             op_b = AW'(r_pos);       end
      S_MAG:  begin op_a = AW'(r_p3);       op_b = AW'(r_m3);        end
      S_TOT1: begin op_a = AW'(r_mag);      op_b = AW'(r_p1);        end
      S_TOT:  begin op_a = acc;             op_b = AW'(r_m1);        end
      S_MUL1: begin op_a = AW'(num) << 6;   op_b = AW'(num) << 5;    end
      S_MUL2: begin op_a = acc;             op_b = AW'(num) << 2;    end
      S_DIV:  begin op_a = acc; op_b = AW'(den) << k; op_sub = 1'b1; end
      default: begin op_a = '0; op_b = '0; op_sub = 1'b0; end
    endcase
  end

  assign sum   = {1'b0, op_a} + {1'b0, (op_sub ? ~op_b : op_b)} + (AW+1)'(op_sub);
  assign ge    = sum[AW];    // no borrow: remainder >= shifted divisor
  assign q_res = den_zero ? '0 : {r_q[PCT_BITS-2:0], ge};

  // ------------------------------------------------------------ gain unit
  gain_req_t            greq;
  logic [GAIN_BITS-1:0] g_coarse, g_fine;

  assign greq.valid     = (state == S_GAIN);
  assign greq.front_end = r_fe;
  assign greq.mag       = r_magpct;

  almagc_gain #(
    .FRONT_ENDS (FRONT_ENDS)
  ) u_gain (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .req         (greq),
    .coarse_gain (g_coarse),
    .fine_gain   (g_fine)
  );

  // ------------------------------------------------------------- sequencer
  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      div_sel   <= 1'b0;
      k         <= '0;
    end else begin
      // S_OUT drives out_valid itself when it loads a new result
      if (out_valid && out_ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            r_fe    <= in_data.front_end;
            r_m3    <= in_data.count_minus3[COUNT_BITS-1:0];
            r_m1    <= in_data.count_minus1[COUNT_BITS-1:0];
            r_p1    <= in_data.count_plus1[COUNT_BITS-1:0];
            r_p3    <= in_data.count_plus3[COUNT_BITS-1:0];
            div_sel <= 1'b0;
            state   <= S_POS3;
          end
        end
        S_POS3: begin acc <= sum[AW-1:0];   state <= S_POS;  end
        S_POS:  begin r_pos <= sum[SW-1:0]; state <= S_SIG3; end
        S_SIG3: begin acc <= sum[AW-1:0];   state <= S_SIG1; end
        S_SIG1: begin acc <= sum[AW-1:0];   state <= S_SIG;  end
        S_SIG:  begin r_sig <= sum[SW-1:0]; state <= S_MAG;  end
        S_MAG:  begin r_mag <= sum[SW-1:0]; state <= S_TOT1; end
        S_TOT1: begin acc <= sum[AW-1:0];   state <= S_TOT;  end
        S_TOT:  begin r_tot <= sum[SW-1:0]; state <= S_MUL1; end
        S_MUL1: begin acc <= sum[AW-1:0];   state <= S_MUL2; end
        S_MUL2: begin
          acc   <= sum[AW-1:0];
          k     <= Q_MSB;
          state <= S_DIV;
        end
        S_DIV: begin
          if (ge) begin
            acc <= sum[AW-1:0];
          end
          r_q <= {r_q[PCT_BITS-2:0], ge};
          if (k == '0) begin
            if (!div_sel) begin
              r_sign  <= q_res;
              div_sel <= 1'b1;
              state   <= S_MUL1;
            end else begin
              r_magpct <= q_res;
              state    <= S_GAIN;
            end
          end else begin
            k <= k - 1'b1;
          end
        end
        S_GAIN: state <= S_OUT;
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid             <= 1'b1;
            out_data.unit         <= r_fe;
            out_data.sign_percent <= r_sign;
            out_data.mag_percent  <= r_magpct;
            out_data.coarse_gain  <= g_coarse;
            out_data.fine_gain    <= g_fine;
            state                 <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  // one item at a time: a transfer in closes the input until S_OUT loads the result
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an item is in progress");

  // percentages never exceed 100
  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.sign_percent <= PCT_FULL) &&
                  (out_data.mag_percent <= PCT_FULL))
    else $error("percentage above 100");

  // unknown front end returns zero gains
  a_unknown_fe: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !(6'(out_data.unit) < 6'(FRONT_ENDS))) |->
      (out_data.coarse_gain == '0) && (out_data.fine_gain == '0))
    else $error("gains reported for an unknown front end");

  // for either percentage, the divisor is never smaller than its numerator
  a_div_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL1) |-> (num <= den))
    else $error("divisor smaller than numerator");
`endif

endmodule

@@ tb/tb_adc_level_monitor_agc.sv @@
// Testbench for adc_level_monitor_agc: directed and random histograms checked against a predictor.
`timescale 1ns / 1ps

module tb_adc_level_monitor_agc import almagc_pkg::*;;

  localparam int FE_COUNT   = 4;
  localparam int CNT_BITS   = 32;
  localparam int MAX_PRINTS = 40;

  // Predicts percentages and per-front-end gains, and holds the results
  // still owed by the block, oldest first.
  class gain_tracker;
    agc_cfg_t             cfg;
    logic [GAIN_BITS-1:0] coarse [FE_COUNT];
    logic [GAIN_BITS-1:0] fine   [FE_COUNT];
    out_item_t            due_results [$];
    int unsigned          mismatches;
    int unsigned          results_seen;

    function new();
      cfg = '{upper_limit: RST_UPPER_LIMIT, lower_limit: RST_LOWER_LIMIT,
              target_level: RST_TARGET_LEVEL, coarse_max: RST_COARSE_MAX,
              fine_low: RST_FINE_LOW, fine_high: RST_FINE_HIGH,
              fine_after_down: RST_FINE_AFTER_DOWN, fine_after_up: RST_FINE_AFTER_UP};
      for (int i = 0; i < FE_COUNT; i++) begin
        coarse[i] = COARSE_RESET;
        fine[i]   = FINE_RESET;
      end
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [31:0] val);
      case (idx)
        REG_UPPER_LIMIT:     cfg.upper_limit     = val[PCT_BITS-1:0];
        REG_LOWER_LIMIT:     cfg.lower_limit     = val[PCT_BITS-1:0];
        REG_TARGET_LEVEL:    cfg.target_level    = val[PCT_BITS-1:0];
        REG_COARSE_MAX:      cfg.coarse_max      = val[GAIN_BITS-1:0];
        REG_FINE_LOW:        cfg.fine_low        = val[GAIN_BITS-1:0];
        REG_FINE_HIGH:       cfg.fine_high       = val[GAIN_BITS-1:0];
        REG_FINE_AFTER_DOWN: cfg.fine_after_down = val[GAIN_BITS-1:0];
        REG_FINE_AFTER_UP:   cfg.fine_after_up   = val[GAIN_BITS-1:0];
        default: ;
      endcase
    endfunction

    // floor(100*num/den), 0 on a zero divisor
    function logic [PCT_BITS-1:0] percent(logic [63:0] num, logic [63:0] den);
      logic [63:0] q;
      if (den == 64'd0) return '0;
      q = (num * 64'd100) / den;
      return q[PCT_BITS-1:0];
    endfunction

    // One control step; first matching rule wins
    function void step_gain(int fe, logic [PCT_BITS-1:0] mag);
      logic [GAIN_BITS-1:0] c;
      logic [GAIN_BITS-1:0] f;
      c = coarse[fe];
      f = fine[fe];
      if ((mag > cfg.upper_limit && c > 0) || f <= cfg.fine_low) begin
        c = (c > 0) ? c - 1'b1 : '0;
        f = cfg.fine_after_down;
      end else if ((mag < cfg.lower_limit && c < cfg.coarse_max) || f >= cfg.fine_high) begin
        c = (c < cfg.coarse_max) ? c + 1'b1 : cfg.coarse_max;
        f = cfg.fine_after_up;
      end else if (mag < cfg.target_level && mag >= cfg.lower_limit) begin
        f = f + 1'b1;
      end else if (mag > cfg.target_level && mag <= cfg.upper_limit) begin
        f = f - 1'b1;
      end
      coarse[fe] = c;
      fine[fe]   = f;
    endfunction

    function void take_snapshot(in_item_t it);
      logic [63:0] m3, m1, p1, p3, pos;
      out_item_t   r;
      m3  = 64'(it.count_minus3);
      m1  = 64'(it.count_minus1);
      p1  = 64'(it.count_plus1);
      p3  = 64'(it.count_plus3);
      pos = 64'd3 * p3 + p1;
      r.unit         = it.front_end;
      r.sign_percent = percent(pos, pos + 64'd3 * m3 + m1);
      r.mag_percent  = percent(p3 + m3, p3 + p1 + m1 + m3);
      if (int'(it.front_end) < FE_COUNT) begin
        step_gain(int'(it.front_end), r.mag_percent);
        r.coarse_gain = coarse[it.front_end];
        r.fine_gain   = fine[it.front_end];
      end else begin
        r.coarse_gain = '0;
        r.fine_gain   = '0;
      end
      due_results.push_back(r);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTS) $display("%0t MISMATCH: %s", $time, msg);
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      results_seen++;
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("result #%0d unit %0d with no snapshot pending",
                                  results_seen, got.unit));
        return;
      end
      want = due_results.pop_front();
      if (got.unit !== want.unit)
        report_mismatch($sformatf("result #%0d unit got %0d want %0d",
                                  results_seen, got.unit, want.unit));
      if (got.sign_percent !== want.sign_percent)
        report_mismatch($sformatf("result #%0d sign_percent got %0d want %0d",
                                  results_seen, got.sign_percent, want.sign_percent));
      if (got.mag_percent !== want.mag_percent)
        report_mismatch($sformatf("result #%0d mag_percent got %0d want %0d",
                                  results_seen, got.mag_percent, want.mag_percent));
      if (got.coarse_gain !== want.coarse_gain)
        report_mismatch($sformatf("result #%0d coarse_gain got %0d want %0d",
                                  results_seen, got.coarse_gain, want.coarse_gain));
      if (got.fine_gain !== want.fine_gain)
        report_mismatch($sformatf("result #%0d fine_gain got %0d want %0d",
                                  results_seen, got.fine_gain, want.fine_gain));
    endtask
  endclass

  // All inputs start at known values; reset is high from time zero.
  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [PADDR_BITS-1:0] paddr     = '0;
  logic [PDATA_BITS-1:0] pwdata    = '0;
  logic [PDATA_BITS-1:0] prdata;
  logic                  pready;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;

  gain_tracker gt = new();

  adc_level_monitor_agc #(
    .FRONT_ENDS (FE_COUNT),
    .COUNT_BITS (CNT_BITS)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Monitors. Everything the TB drives changes by NBA and the DUT outputs
  // come from registers, so at the edge these reads see pre-edge values:
  // exactly what the DUT sampled for the transfer.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) gt.take_snapshot(in_data);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) gt.check_result(out_data);
  end

  // Receiver: ready follows a randomly redrawn 8-bit pattern (a quarter of
  // the draws give no stalls at all). Twice, once enough results are in, ready
  // is held low while the sender keeps offering, so the output
  // register and the core both fill and in_ready goes low.
  initial begin : receiver
    logic [7:0]  pattern;
    int unsigned slot;
    int unsigned hold;
    int unsigned next_hold;
    pattern   = 8'hFF;
    slot      = 0;
    hold      = 0;
    next_hold = 90;
    forever begin
      @(posedge clk);
      if (hold == 0 && gt.results_seen >= next_hold) begin
        hold      = 400;
        next_hold = next_hold + 360;
      end
      if (hold != 0) begin
        hold = hold - 1;
        out_ready <= 1'b0;
      end else begin
        if (slot % 64 == 0)
          pattern = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
        out_ready <= pattern[slot % 8];
        slot = slot + 1;
      end
    end
  end

  // Hard stop well past the slowest legal run
  initial begin
    #5_000_000;
    $display("adc_level_monitor_agc test failed");
    $finish;
  end

  function automatic in_item_t snapshot(logic [1:0] fe, logic [31:0] m3, logic [31:0] m1,
                                        logic [31:0] p1, logic [31:0] p3);
    in_item_t it;
    it.front_end    = fe;
    it.count_minus3 = m3;
    it.count_minus1 = m1;
    it.count_plus1  = p1;
    it.count_plus3  = p3;
    return it;
  endfunction

  // Mostly histograms with a chosen outer-level share so the magnitude
  // sweeps across all the gain thresholds; the rest is raw noise and
  // sparse histograms with zero and full-scale bins.
  function automatic in_item_t random_snapshot();
    in_item_t    it;
    logic [31:0] n, outer, inner, a;
    int unsigned mode, k, t;
    it.front_end = 2'($urandom_range(0, 3));
    mode = $urandom_range(0, 9);
    if (mode < 7) begin
      k = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 12) : $urandom_range(13, 32);
      n = (k == 32) ? $urandom : ($urandom & ((32'd1 << k) - 32'd1));
      t = $urandom_range(0, 100);
      outer = 32'((64'(n) * 64'(t)) / 64'd100);
      inner = n - outer;
      a = (outer == 0) ? 32'd0 : 32'($urandom_range(0, outer));
      it.count_plus3  = a;
      it.count_minus3 = outer - a;
      a = (inner == 0) ? 32'd0 : 32'($urandom_range(0, inner));
      it.count_plus1  = a;
      it.count_minus1 = inner - a;
    end else if (mode < 9) begin
      it.count_minus3 = $urandom;
      it.count_minus1 = $urandom;
      it.count_plus1  = $urandom;
      it.count_plus3  = $urandom;
    end else begin
      it.count_minus3 = ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom_range(0, 15);
      it.count_minus1 = ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom_range(0, 15);
      it.count_plus1  = ($urandom_range(0, 2) == 0) ? 32'd0 : '1;
      it.count_plus3  = ($urandom_range(0, 2) == 0) ? 32'd0 : '1;
    end
    return it;
  endfunction

  function automatic agc_cfg_t random_cfg();
    agc_cfg_t    c;
    int unsigned lo, tg, up, fl;
    lo = $urandom_range(5, 40);
    tg = lo + $urandom_range(0, 20);
    up = tg + $urandom_range(0, 40);
    if (up > 100) up = 100;
    fl = $urandom_range(0, 20);
    c.lower_limit     = 7'(lo);
    c.target_level    = 7'(tg);
    c.upper_limit     = 7'(up);
    c.coarse_max      = 6'($urandom_range(1, 63));
    c.fine_low        = 6'(fl);
    c.fine_high       = 6'($urandom_range(fl + 1, 63));
    c.fine_after_down = 6'($urandom_range(0, 63));
    c.fine_after_up   = 6'($urandom_range(0, 63));
    return c;
  endfunction

  // Holds the item until the transfer. Valid is not lowered here, so a
  // back-to-back item is just a new payload at the transfer edge.
  task automatic offer(in_item_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  // Sender gap; junk on the payload while valid is low
  task automatic pause_sender(int unsigned n);
    in_valid <= 1'b0;
    in_data  <= random_snapshot();
    repeat (n) @(posedge clk);
  endtask

  // Every item yields exactly one result, so once nothing is owed the
  // core is idle; the extra cycles only cover the output register.
  task automatic drain(int unsigned tail);
    in_valid <= 1'b0;
    while (gt.due_results.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  // APB write, setup then access. psel stays up between back-to-back
  // writes; the caller drops it after the last one.
  task automatic apb_write(reg_idx_t idx, logic [31:0] field, logic [31:0] keep);
    logic [31:0] val;
    val = ($urandom & ~keep) | (field & keep);    // junk above the field width
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    gt.write_reg(idx, val);
  endtask

  task automatic program_config(agc_cfg_t c);
    apb_write(REG_UPPER_LIMIT,     32'(c.upper_limit),     32'h7F);
    apb_write(REG_LOWER_LIMIT,     32'(c.lower_limit),     32'h7F);
    apb_write(REG_TARGET_LEVEL,    32'(c.target_level),    32'h7F);
    apb_write(REG_COARSE_MAX,      32'(c.coarse_max),      32'h3F);
    apb_write(REG_FINE_LOW,        32'(c.fine_low),        32'h3F);
    apb_write(REG_FINE_HIGH,       32'(c.fine_high),       32'h3F);
    apb_write(REG_FINE_AFTER_DOWN, 32'(c.fine_after_down), 32'h3F);
    apb_write(REG_FINE_AFTER_UP,   32'(c.fine_after_up),   32'h3F);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_directed();
    offer(snapshot(2'd0, '0, '0, '0, '0));           // both divisors zero
    offer(snapshot(2'd1, '1, '1, '1, '1));           // full scale, sums past 32 bits
    offer(snapshot(2'd2, '1, '0, '0, '0));           // all at -3
    offer(snapshot(2'd3, '0, '0, '0, '1));           // all at +3
    offer(snapshot(2'd0, '0, 32'd1, '0, '0));        // single -1 sample
    offer(snapshot(2'd1, '0, '0, 32'd1, '0));        // single +1 sample
    // magnitude exactly on and next to the default thresholds
    offer(snapshot(2'd2, 32'd10, 32'd40, 32'd40, 32'd10));
    offer(snapshot(2'd2, 32'd15, 32'd35, 32'd35, 32'd15));
    offer(snapshot(2'd2, 32'd20, 32'd30, 32'd30, 32'd20));
    offer(snapshot(2'd2, 32'd21, 32'd30, 32'd29, 32'd20));
    offer(snapshot(2'd3, 32'd9, 32'd40, 32'd41, 32'd10));
    offer(snapshot(2'd3, 32'd14, 32'd36, 32'd35, 32'd15));
    offer(snapshot(2'd3, 32'd16, 32'd34, 32'd35, 32'd15));
    // floors: 1/3 and 3/5
    offer(snapshot(2'd1, 32'd1, 32'd2, '0, '0));
    offer(snapshot(2'd1, '0, 32'd2, '0, 32'd1));
    // walk coarse gain down on one unit and up on another
    repeat (5) offer(snapshot(2'd0, 32'd500, '0, '0, 32'd700));
    repeat (5) offer(snapshot(2'd3, '0, 32'd900, 32'd800, '0));
  endtask

  // Bursts of 1..8 items (sometimes up to 30) separated by sender pauses (a quarter of the time none)
  task automatic run_random(int unsigned n);
    int unsigned burst;
    int unsigned gap;
    burst = $urandom_range(1, 8);
    for (int unsigned i = 0; i < n; i++) begin
      offer(random_snapshot());
      burst = burst - 1;
      if (burst == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap != 0) pause_sender(gap);
        burst = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 30 : 8);
      end
    end
  endtask

  initial begin : stimulus
    agc_cfg_t hi_cfg;
    agc_cfg_t lo_cfg;
    hi_cfg = '{upper_limit: 7'd100, lower_limit: 7'd0, target_level: 7'd100,
               coarse_max: 6'd63, fine_low: 6'd0, fine_high: 6'd63,
               fine_after_down: 6'd63, fine_after_up: 6'd0};
    lo_cfg = '{upper_limit: 7'd100, lower_limit: 7'd100, target_level: 7'd0,
               coarse_max: 6'd0, fine_low: 6'd0, fine_high: 6'd0,
               fine_after_down: 6'd0, fine_after_up: 6'd63};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset register values first
    run_directed();
    run_random(180);
    drain(30);

    // Wide-open thresholds, then the opposite corner; the second one also
    // pulls every coarse gain that grew above the new coarse_max
    program_config(hi_cfg);
    run_random(100);
    drain(30);
    program_config(lo_cfg);
    run_random(100);
    drain(30);

    // Two ordinary settings
    program_config(random_cfg());
    run_random(150);
    drain(30);
    program_config(random_cfg());
    run_random(150);

    drain(40);
    if (gt.due_results.size() != 0)
      gt.report_mismatch($sformatf("%0d results never arrived", gt.due_results.size()));
    if (gt.mismatches == 0) begin
      $display("adc_level_monitor_agc test passed");
    end else begin
      $display("adc_level_monitor_agc test failed");
    end
    $finish;
  end

endmodule
